// ===== rtl/sbad_pkg.sv =====
// ----------------------------------------------------------------------------
// sbad_pkg: shared constants and types for the binary to ASCII decimal core
// Widths of the value, the BCD scratch word and the counters, plus the
// character codes written on the output.
// ----------------------------------------------------------------------------
package sbad_pkg;

    localparam int VALUE_BITS = 16;

    // Number of decimal digits needed for the largest magnitude, 2^(VALUE_BITS-1)
    function automatic int digits_for(int bits);
        longint v;
        int     d;
        v = longint'(1) << (bits - 1);
        d = 1;
        while (v >= 10) begin
            v = v / 10;
            d = d + 1;
        end
        return d;
    endfunction

    localparam int MAX_DIGITS   = digits_for(VALUE_BITS);
    localparam int BCD_BITS     = 4 * MAX_DIGITS;
    localparam int CNT_BITS     = $clog2(VALUE_BITS + 1);
    localparam int DIG_CNT_BITS = $clog2(MAX_DIGITS + 1);
    localparam int CHAR_BITS    = 7;

    typedef logic [VALUE_BITS-1:0]   t_value;
    typedef logic [BCD_BITS-1:0]     t_bcd;
    typedef logic [CNT_BITS-1:0]     t_cnt;
    typedef logic [DIG_CNT_BITS-1:0] t_dig_cnt;
    typedef logic [CHAR_BITS-1:0]    t_char;

    localparam t_char CODE_ZERO  = 7'd48;
    localparam t_char CODE_MINUS = 7'd45;
    localparam t_char CODE_NINE  = 7'd57;

endpackage

// ===== rtl/signed_binary_to_ascii_decimal_core.sv =====
// ----------------------------------------------------------------------------
// signed_binary_to_ascii_decimal_core: signed value to ASCII decimal text
// Takes a signed value and sends its decimal form one character per beat:
// optional minus, then digits most significant first, last one flagged.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  input     in         i_valid / o_stall  i_value (16 bit signed)
//  output    out        o_valid / i_stall  o_ascii_char (7 bit), o_last_char
//
//  A value passes through the shift-and-add-3 converter and its result is
//  captured; leading zeros are then skipped, an optional minus sign is sent,
//  and the digits are sent most significant first before the core returns to
//  idle. Each character waits until the output register is free.
//  The converter is the single shared unit; o_stall is high until the last
//  character is in the output register. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
module signed_binary_to_ascii_decimal_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  sbad_pkg::t_value     i_value,
    output logic                 o_valid,
    input  logic                 i_stall,
    output sbad_pkg::t_char      o_ascii_char,
    output logic                 o_last_char
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_SIGN,
        S_DIGIT
    } t_state;

    t_state             r_state;
    logic               r_neg;
    sbad_pkg::t_bcd     r_digits;
    sbad_pkg::t_dig_cnt r_left;
    logic               r_o_valid;
    sbad_pkg::t_char    r_o_char;
    logic               r_o_last;

    logic               w_start;
    logic               w_neg_in;
    sbad_pkg::t_value   w_mag;
    logic               w_done;
    sbad_pkg::t_bcd     w_bcd;
    logic               w_slot_free;
    logic [3:0]         w_top;

    assign w_neg_in    = i_value[sbad_pkg::VALUE_BITS-1];
    assign w_mag       = w_neg_in ? (~i_value + sbad_pkg::t_value'(1)) : i_value;
    assign w_start     = i_valid && (r_state == S_IDLE);
    assign w_slot_free = !r_o_valid || !i_stall;
    assign w_top       = r_digits[sbad_pkg::BCD_BITS-1 -: 4];

    sbad_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_mag   (w_mag),
        .o_done  (w_done),
        .o_bcd   (w_bcd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            // load a beat in the send states, else drop the one just taken
            if (w_slot_free) begin
                r_o_valid <= (r_state == S_SIGN) || (r_state == S_DIGIT);
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_neg   <= w_neg_in;
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    if (w_done) begin
                        r_digits <= w_bcd;
                        r_left   <= sbad_pkg::t_dig_cnt'(sbad_pkg::MAX_DIGITS);
                        r_state  <= S_SKIP;
                    end
                end
                S_SKIP: begin
                    // drop leading zeros, keep at least one digit
                    if (w_top == 4'd0 && r_left != sbad_pkg::t_dig_cnt'(1)) begin
                        r_digits <= {r_digits[sbad_pkg::BCD_BITS-5:0], 4'd0};
                        r_left   <= r_left - sbad_pkg::t_dig_cnt'(1);
                    end else begin
                        r_state <= r_neg ? S_SIGN : S_DIGIT;
                    end
                end
                S_SIGN: begin
                    if (w_slot_free) begin
                        r_o_char  <= sbad_pkg::CODE_MINUS;
                        r_o_last  <= 1'b0;
                        r_state   <= S_DIGIT;
                    end
                end
                S_DIGIT: begin
                    if (w_slot_free) begin
                        r_o_char  <= sbad_pkg::CODE_ZERO + sbad_pkg::t_char'(w_top);
                        r_o_last  <= (r_left == sbad_pkg::t_dig_cnt'(1));
                        r_digits  <= {r_digits[sbad_pkg::BCD_BITS-5:0], 4'd0};
                        r_left    <= r_left - sbad_pkg::t_dig_cnt'(1);
                        if (r_left == sbad_pkg::t_dig_cnt'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_o_valid;
    assign o_ascii_char = r_o_char;
    assign o_last_char  = r_o_last;

    a_char_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_ascii_char == sbad_pkg::CODE_MINUS ||
                     (o_ascii_char >= sbad_pkg::CODE_ZERO &&
                      o_ascii_char <= sbad_pkg::CODE_NINE)))
        else $error("output character is neither a digit nor a minus sign");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_ascii_char == sbad_pkg::CODE_MINUS) |-> !o_last_char)
        else $error("minus sign flagged as last character");

    a_accept_to_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_CONV))
        else $error("accepted value did not start conversion");

    a_done_in_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == S_CONV))
        else $error("converter finished outside the conversion state");

endmodule

// ===== rtl/sbad_conv.sv =====
// ----------------------------------------------------------------------------
// sbad_conv: iterative binary to BCD converter
// One shift-and-add-3 step per cycle over all BCD digits, VALUE_BITS steps
// per magnitude. Pulses o_done when the BCD word is final.
// ----------------------------------------------------------------------------
module sbad_conv (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  sbad_pkg::t_value i_mag,
    output logic            o_done,
    output sbad_pkg::t_bcd  o_bcd
);

    logic             r_busy;
    logic             r_done;
    sbad_pkg::t_cnt   r_cnt;
    sbad_pkg::t_value r_mag;
    sbad_pkg::t_bcd   r_bcd;
    sbad_pkg::t_bcd   w_adj;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        w_adj = r_bcd;
        for (int d = 0; d < sbad_pkg::MAX_DIGITS; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                w_adj[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= sbad_pkg::t_cnt'(sbad_pkg::VALUE_BITS);
                r_mag  <= i_mag;
                r_bcd  <= '0;
            end else if (r_busy) begin
                r_bcd <= {w_adj[sbad_pkg::BCD_BITS-2:0], r_mag[sbad_pkg::VALUE_BITS-1]};
                r_mag <= {r_mag[sbad_pkg::VALUE_BITS-2:0], 1'b0};
                r_cnt <= r_cnt - sbad_pkg::t_cnt'(1);
                if (r_cnt == sbad_pkg::t_cnt'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: signed binary to ASCII decimal core
// Sends signed 16-bit values and checks every character beat on the output
// against a decimal conversion worked out here: minus sign, digits without
// leading zeros, last-character flag. Covers edge values, random values of
// every length, random idling on both sides and a long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 64;

    typedef struct {
        sbad_pkg::t_char code;
        logic            last;
    } t_glyph;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    sbad_pkg::t_value i_value;
    logic             o_valid;
    logic             i_stall;
    sbad_pkg::t_char  o_ascii_char;
    logic             o_last_char;

    t_glyph pending_glyphs[$];
    int     fail_count;
    int     quiet_cycles;
    bit     gaps_on;
    bit     stall_hold_req;

    signed_binary_to_ascii_decimal_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_ascii_char (o_ascii_char),
        .o_last_char  (o_last_char)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Queue the characters this value should produce
    function automatic void predict_text(input sbad_pkg::t_value v);
        longint          mag;
        sbad_pkg::t_char digs[$];
        bit              neg;
        t_glyph          g;
        neg = v[sbad_pkg::VALUE_BITS-1];
        mag = longint'($signed(v));
        if (neg) mag = -mag;
        if (mag == 0) digs.push_front(sbad_pkg::CODE_ZERO);
        while (mag != 0) begin
            digs.push_front(sbad_pkg::CODE_ZERO + sbad_pkg::t_char'(mag % 10));
            mag = mag / 10;
        end
        if (neg) begin
            g.code = sbad_pkg::CODE_MINUS;
            g.last = 1'b0;
            pending_glyphs.push_back(g);
        end
        foreach (digs[i]) begin
            g.code = digs[i];
            g.last = (i == digs.size() - 1);
            pending_glyphs.push_back(g);
        end
    endfunction

    task automatic send_number(input sbad_pkg::t_value v);
        int n;
        @(negedge i_clk);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 11);
            i_valid = 1'b0;
            repeat (n) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_value = v;
        // hold the beat until the core takes it
        do @(posedge i_clk); while (o_stall);
        predict_text(v);
    endtask

    task automatic wait_text_drained;
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_glyphs.size() != 0) @(posedge i_clk);
    endtask

    function automatic sbad_pkg::t_value random_value;
        longint mag;
        case ($urandom_range(0, 5))
            0: return sbad_pkg::t_value'($urandom);
            1: mag = $urandom_range(0, 9);
            2: mag = $urandom_range(10, 99);
            3: mag = $urandom_range(100, 999);
            4: mag = $urandom_range(1000, 9999);
            default: mag = $urandom_range(10000, 32767);
        endcase
        if ($urandom_range(0, 1)) mag = -mag;
        return sbad_pkg::t_value'(mag);
    endfunction

    task automatic test_edge_values;
        sbad_pkg::t_value vals[$];
        vals = {16'sd0, 16'sd1, -16'sd1, 16'sd9, 16'sd10, -16'sd10, 16'sd99,
                16'sd100, -16'sd999, 16'sd1000, 16'sd9999, 16'sd10000,
                -16'sd9999, -16'sd10000, 16'sd32767, 16'h8000, -16'sd32767,
                16'sd12345, -16'sd5, 16'h5555, 16'hAAAA, 16'sd20001};
        foreach (vals[i]) send_number(vals[i]);
        wait_text_drained();
    endtask

    task automatic test_output_hold;
        stall_hold_req = 1'b1;
        // keep offering beats so the core fills and stalls its input
        repeat (12) send_number(random_value());
        wait_text_drained();
    endtask

    task automatic test_random_values(input int count);
        for (int i = 0; i < count; i++) begin
            send_number(random_value());
            if (i % 100 == 99) wait_text_drained();
        end
        wait_text_drained();
    endtask

    task automatic test_back_to_back(input int count);
        gaps_on = 1'b0;
        repeat (count) send_number(random_value());
        wait_text_drained();
    endtask

    // Output side: random stall bursts, plus one long hold on request
    initial begin : rx_stall_gen
        int n;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_hold_req) begin
                i_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                stall_hold_req = 1'b0;
                i_stall = 1'b0;
            end else if (gaps_on && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 11);
                i_stall = 1'b1;
                repeat (n) @(negedge i_clk);
                i_stall = 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : check_beat
        t_glyph want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_glyphs.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected beat, expected none, actual char %0d last %0b",
                         $time, o_ascii_char, o_last_char);
            end else begin
                want = pending_glyphs.pop_front();
                if (o_ascii_char !== want.code) begin
                    fail_count++;
                    $display("%0t: char mismatch, expected %0d, actual %0d",
                             $time, want.code, o_ascii_char);
                end
                if (o_last_char !== want.last) begin
                    fail_count++;
                    $display("%0t: last flag mismatch, expected %0b, actual %0b",
                             $time, want.last, o_last_char);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        fail_count     = 0;
        quiet_cycles   = 0;
        gaps_on        = 1'b1;
        stall_hold_req = 1'b0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_value        = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_edge_values();
        test_output_hold();
        test_random_values(380);
        test_back_to_back(40);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_glyphs.size() != 0) begin
            fail_count++;
            $display("%0t: %0d characters never arrived", $time, pending_glyphs.size());
        end
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
